/* design/ebcalu_pkg.sv */
// Package for the 8-bit CPU ALU: operation codes, flag positions and pipeline stage types.
package ebcalu_pkg;

    localparam int OP_W   = 5;
    localparam int ACC_W  = 16;
    localparam int FLAG_W = 8;

    // flag bit positions
    localparam int FLAG_Z = 7;
    localparam int FLAG_N = 6;
    localparam int FLAG_H = 5;
    localparam int FLAG_C = 4;

    localparam logic [7:0] DAA_LIMIT = 8'h99;
    localparam logic [7:0] DAA_HI    = 8'h60;
    localparam logic [7:0] DAA_LO    = 8'h06;
    localparam logic [3:0] DAA_NIB   = 4'h9;

    typedef enum logic [OP_W-1:0] {
        OP_LD8   = 5'd0,
        OP_LD16  = 5'd1,
        OP_ADD8  = 5'd2,
        OP_ADC8  = 5'd3,
        OP_SUB8  = 5'd4,
        OP_SBC8  = 5'd5,
        OP_INC8  = 5'd6,
        OP_DEC8  = 5'd7,
        OP_ADD16 = 5'd8,
        OP_SUB16 = 5'd9,
        OP_INC16 = 5'd10,
        OP_DEC16 = 5'd11,
        OP_AND   = 5'd12,
        OP_XOR   = 5'd13,
        OP_OR    = 5'd14,
        OP_CP    = 5'd15,
        OP_BIT   = 5'd16,
        OP_SET   = 5'd17,
        OP_RES   = 5'd18,
        OP_CPL   = 5'd19,
        OP_RL    = 5'd20,
        OP_RR    = 5'd21,
        OP_RLC   = 5'd22,
        OP_RRC   = 5'd23,
        OP_SLA   = 5'd24,
        OP_SRA   = 5'd25,
        OP_SRL   = 5'd26,
        OP_DAA   = 5'd27,
        OP_CCF   = 5'd28,
        OP_SCF   = 5'd29,
        OP_SWAP  = 5'd30
    } alu_op_t;

    // where the zero flag comes from
    typedef enum logic [1:0] {
        ZS_BIT,
        ZS_R8,
        ZS_R16
    } zsrc_t;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } znhc_t;

    // stage 1: operands and adder outputs
    typedef struct packed {
        alu_op_t            op;
        logic [ACC_W-1:0]   a16;
        logic [ACC_W-1:0]   b16;
        logic [FLAG_W-1:0]  f;
        logic [8:0]         sum8;
        logic               hc8;
        logic [8:0]         dif8;
        logic               hb8;
        logic [16:0]        sum16;
        logic               hc16;
        logic [16:0]        dif16;
        logic [7:0]         daa_k;
        logic               daa_c;
    } s1_t;

    // stage 2: selected result and flag values
    typedef struct packed {
        logic [ACC_W-1:0]   r16;
        logic [FLAG_W-1:0]  f;
        zsrc_t              zsrc;
        logic               zbit;
        znhc_t              val;
        znhc_t              wr;
    } s2_t;

    // stage 3: output word
    typedef struct packed {
        logic [ACC_W-1:0]   acc;
        logic [FLAG_W-1:0]  flags;
    } s3_t;

endpackage

/* design/ebcalu_if.sv */
// Request and response channel interfaces of the 8-bit CPU ALU.
interface ebcalu_req_if;
    import ebcalu_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   req_type;
    logic [ACC_W-1:0]  acc_in;
    logic [ACC_W-1:0]  operand_b;
    logic [FLAG_W-1:0] flags_in;

    modport source (output valid, output req_type, output acc_in, output operand_b,
                    output flags_in, input ready);
    modport sink   (input valid, input req_type, input acc_in, input operand_b,
                    input flags_in, output ready);
endinterface

interface ebcalu_rsp_if;
    import ebcalu_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACC_W-1:0]  acc_out;
    logic [FLAG_W-1:0] flags_out;

    modport source (output valid, output acc_out, output flags_out, input ready);
    modport sink   (input valid, input acc_out, input flags_out, output ready);
endinterface

/* design/eight_bit_cpu_alu_with_flags_top.sv */
// 8-bit CPU ALU with Z/N/H/C flags: three-stage pipeline, one word per cycle while the receiver is ready.
//
// A request word (operation, accumulator, second operand, flag byte) gives one
// response word (new accumulator, new flag byte). The response word is registered
// in stage 1, stage 2 and stage 3 in turn; while the receiver is ready, a new
// word is taken every cycle, so throughput is one word per clock. Stage 1 holds
// the 8- and 16-bit adders and subtractors, stage 2 the result and flag selection
// (rotates, logic, DAA correction), stage 3 zero detection and the flag merge into
// the output register. Each stage carries its own valid bit and moves as soon as
// the stage after it is empty or moving, so back-pressure is absorbed without
// losing or repeating a word. Flag bits 3..0 pass through unchanged.
module eight_bit_cpu_alu_with_flags_top
(
    input  logic                clk,
    input  logic                rst_n,
    ebcalu_req_if.sink          req,
    ebcalu_rsp_if.source        rsp
);
    import ebcalu_pkg::*;

    logic  v1_reg, v2_reg, v3_reg;
    s1_t   s1_reg, s1_next;
    s2_t   s2_reg, s2_next;
    s3_t   s3_reg, s3_next;
    logic  en1, en2, en3;

    // stall chain
    assign en3 = !v3_reg || rsp.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign req.ready     = en1;
    assign rsp.valid     = v3_reg;
    assign rsp.acc_out   = s3_reg.acc;
    assign rsp.flags_out = s3_reg.flags;

    // ---------------- stage 1: adders ----------------
    alu_op_t     op_a;
    logic [7:0]  a8_a, b8_a, y8_a;
    logic [15:0] y16_a;
    logic        cin_a, ci_a, bi_a, fn_a, fh_a, klo_a, khi_a;
    logic [4:0]  hsum_a, hdif_a;
    logic [12:0] h12_a;

    always_comb
    begin
        op_a  = alu_op_t'(req.req_type);
        a8_a  = req.acc_in[7:0];
        b8_a  = req.operand_b[7:0];
        cin_a = req.flags_in[FLAG_C];
        fn_a  = req.flags_in[FLAG_N];
        fh_a  = req.flags_in[FLAG_H];
        ci_a  = (op_a == OP_ADC8) ? cin_a : 1'b0;
        bi_a  = (op_a == OP_SBC8) ? cin_a : 1'b0;
        y8_a  = (op_a == OP_INC8 || op_a == OP_DEC8) ? 8'd1 : b8_a;
        y16_a = (op_a == OP_INC16 || op_a == OP_DEC16) ? 16'd1 : req.operand_b;

        hsum_a = {1'b0, a8_a[3:0]} + {1'b0, y8_a[3:0]} + {4'd0, ci_a};
        hdif_a = {1'b0, a8_a[3:0]} - {1'b0, y8_a[3:0]} - {4'd0, bi_a};
        h12_a  = {1'b0, req.acc_in[11:0]} + {1'b0, y16_a[11:0]};

        klo_a = fh_a || (!fn_a && (a8_a[3:0] > DAA_NIB));
        khi_a = cin_a || (!fn_a && (a8_a > DAA_LIMIT));

        s1_next.op    = op_a;
        s1_next.a16   = req.acc_in;
        s1_next.b16   = req.operand_b;
        s1_next.f     = req.flags_in;
        s1_next.sum8  = {1'b0, a8_a} + {1'b0, y8_a} + {8'd0, ci_a};
        s1_next.hc8   = hsum_a[4];
        s1_next.dif8  = {1'b0, a8_a} - {1'b0, y8_a} - {8'd0, bi_a};
        s1_next.hb8   = hdif_a[4];
        s1_next.sum16 = {1'b0, req.acc_in} + {1'b0, y16_a};
        s1_next.hc16  = h12_a[12];
        s1_next.dif16 = {1'b0, req.acc_in} - {1'b0, y16_a};
        s1_next.daa_k = (khi_a ? DAA_HI : 8'h00) | (klo_a ? DAA_LO : 8'h00);
        s1_next.daa_c = khi_a;
    end

    // ---------------- stage 2: result select ----------------
    logic [7:0] a8_b, b8_b, mask_b;
    logic       cin_b;

    always_comb
    begin
        a8_b   = s1_reg.a16[7:0];
        b8_b   = s1_reg.b16[7:0];
        cin_b  = s1_reg.f[FLAG_C];
        mask_b = 8'd1 << s1_reg.b16[2:0];

        s2_next.r16  = s1_reg.a16;
        s2_next.f    = s1_reg.f;
        s2_next.zsrc = ZS_R8;
        s2_next.zbit = 1'b0;
        s2_next.val  = '0;
        s2_next.wr   = '0;

        unique case (s1_reg.op)
            OP_LD8:  s2_next.r16 = {8'h00, b8_b};
            OP_LD16: s2_next.r16 = s1_reg.b16;
            OP_ADD8, OP_ADC8, OP_INC8:
            begin
                s2_next.r16   = {8'h00, s1_reg.sum8[7:0]};
                s2_next.val.h = s1_reg.hc8;
                s2_next.val.c = s1_reg.sum8[8];
                s2_next.wr    = '{z: 1'b1, n: 1'b1, h: 1'b1, c: (s1_reg.op != OP_INC8)};
            end
            OP_SUB8, OP_SBC8, OP_DEC8:
            begin
                s2_next.r16   = {8'h00, s1_reg.dif8[7:0]};
                s2_next.val.n = 1'b1;
                s2_next.val.h = s1_reg.hb8;
                s2_next.val.c = s1_reg.dif8[8];
                s2_next.wr    = '{z: 1'b1, n: 1'b1, h: 1'b1, c: (s1_reg.op != OP_DEC8)};
            end
            OP_CP:
            begin
                // zero test on the difference, accumulator kept
                s2_next.zsrc  = ZS_BIT;
                s2_next.zbit  = (s1_reg.dif8[7:0] == 8'h00);
                s2_next.val.n = 1'b1;
                s2_next.val.h = s1_reg.hb8;
                s2_next.val.c = s1_reg.dif8[8];
                s2_next.wr    = '1;
            end
            OP_ADD16:
            begin
                s2_next.r16   = s1_reg.sum16[15:0];
                s2_next.val.h = s1_reg.hc16;
                s2_next.val.c = s1_reg.sum16[16];
                s2_next.wr    = '{z: 1'b0, n: 1'b1, h: 1'b1, c: 1'b1};
            end
            OP_SUB16:
            begin
                s2_next.r16   = s1_reg.dif16[15:0];
                s2_next.zsrc  = ZS_R16;
                s2_next.val.n = 1'b1;
                s2_next.val.h = s1_reg.dif8[8];
                s2_next.val.c = s1_reg.dif16[16];
                s2_next.wr    = '1;
            end
            OP_INC16: s2_next.r16 = s1_reg.sum16[15:0];
            OP_DEC16: s2_next.r16 = s1_reg.dif16[15:0];
            OP_AND:
            begin
                s2_next.r16   = {8'h00, a8_b & b8_b};
                s2_next.val.h = 1'b1;
                s2_next.wr    = '1;
            end
            OP_XOR:
            begin
                s2_next.r16 = {8'h00, a8_b ^ b8_b};
                s2_next.wr  = '1;
            end
            OP_OR:
            begin
                s2_next.r16 = {8'h00, a8_b | b8_b};
                s2_next.wr  = '1;
            end
            OP_BIT:
            begin
                s2_next.zsrc  = ZS_BIT;
                s2_next.zbit  = ((a8_b & mask_b) == 8'h00);
                s2_next.val.h = 1'b1;
                s2_next.wr    = '{z: 1'b1, n: 1'b1, h: 1'b1, c: 1'b0};
            end
            OP_SET:  s2_next.r16 = {8'h00, a8_b | mask_b};
            OP_RES:  s2_next.r16 = {8'h00, a8_b & ~mask_b};
            OP_CPL:
            begin
                s2_next.r16   = {8'h00, ~a8_b};
                s2_next.val.n = 1'b1;
                s2_next.val.h = 1'b1;
                s2_next.wr    = '{z: 1'b0, n: 1'b1, h: 1'b1, c: 1'b0};
            end
            OP_RL:
            begin
                s2_next.r16   = {8'h00, a8_b[6:0], cin_b};
                s2_next.val.c = a8_b[7];
                s2_next.wr    = '1;
            end
            OP_RR:
            begin
                s2_next.r16   = {8'h00, cin_b, a8_b[7:1]};
                s2_next.val.c = a8_b[0];
                s2_next.wr    = '1;
            end
            OP_RLC:
            begin
                s2_next.r16   = {8'h00, a8_b[6:0], a8_b[7]};
                s2_next.val.c = a8_b[7];
                s2_next.wr    = '1;
            end
            OP_RRC:
            begin
                s2_next.r16   = {8'h00, a8_b[0], a8_b[7:1]};
                s2_next.val.c = a8_b[0];
                s2_next.wr    = '1;
            end
            OP_SLA:
            begin
                s2_next.r16   = {8'h00, a8_b[6:0], 1'b0};
                s2_next.val.c = a8_b[7];
                s2_next.wr    = '1;
            end
            OP_SRA:
            begin
                s2_next.r16   = {8'h00, a8_b[7], a8_b[7:1]};
                s2_next.val.c = a8_b[0];
                s2_next.wr    = '1;
            end
            OP_SRL:
            begin
                s2_next.r16   = {8'h00, 1'b0, a8_b[7:1]};
                s2_next.val.c = a8_b[0];
                s2_next.wr    = '1;
            end
            OP_DAA:
            begin
                // N selects subtract or add of the correction
                s2_next.r16   = {8'h00, s1_reg.f[FLAG_N] ? (a8_b - s1_reg.daa_k)
                                                         : (a8_b + s1_reg.daa_k)};
                s2_next.val.n = s1_reg.f[FLAG_N];
                s2_next.val.c = s1_reg.daa_c;
                s2_next.wr    = '1;
            end
            OP_CCF:
            begin
                s2_next.val.c = !cin_b;
                s2_next.wr    = '{z: 1'b0, n: 1'b1, h: 1'b1, c: 1'b1};
            end
            OP_SCF:
            begin
                s2_next.val.c = 1'b1;
                s2_next.wr    = '{z: 1'b0, n: 1'b1, h: 1'b1, c: 1'b1};
            end
            OP_SWAP:
            begin
                s2_next.r16 = {8'h00, a8_b[3:0], a8_b[7:4]};
                s2_next.wr  = '1;
            end
            default:
            begin
                s2_next.r16 = s1_reg.a16;
            end
        endcase
    end

    // ---------------- stage 3: zero flag and merge ----------------
    logic z_c;

    always_comb
    begin
        case (s2_reg.zsrc)
            ZS_R16:  z_c = (s2_reg.r16 == 16'h0000);
            ZS_R8:   z_c = (s2_reg.r16[7:0] == 8'h00);
            default: z_c = s2_reg.zbit;
        endcase

        s3_next.acc   = s2_reg.r16;
        s3_next.flags = s2_reg.f;
        if (s2_reg.wr.z)
        begin
            s3_next.flags[FLAG_Z] = z_c;
        end
        if (s2_reg.wr.n)
        begin
            s3_next.flags[FLAG_N] = s2_reg.val.n;
        end
        if (s2_reg.wr.h)
        begin
            s3_next.flags[FLAG_H] = s2_reg.val.h;
        end
        if (s2_reg.wr.c)
        begin
            s3_next.flags[FLAG_C] = s2_reg.val.c;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= req.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && req.valid)
        begin
            s1_reg <= s1_next;
        end
        if (en2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (en3 && v2_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    // ---------------- assertions ----------------
    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (v1_reg && v2_reg && v3_reg))
        else $error("input stalled with a free pipeline stage");

    a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && en2) |=> (v2_reg && s2_reg.f == $past(s1_reg.f)))
        else $error("stage 1 word lost on its way to stage 2");

    a_s2_to_s3: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && en3) |=> v3_reg)
        else $error("stage 2 word lost on its way to the output");

    a_low_nibble: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && en3) |=> (rsp.flags_out[3:0] == $past(s2_reg.f[3:0])))
        else $error("low flag nibble altered");

endmodule

/* sim/eight_bit_cpu_alu_with_flags_top_test.sv */
// Testbench for the 8-bit CPU ALU: bursty request words, stalling receiver, scoreboard check.
module eight_bit_cpu_alu_with_flags_top_test;
    import ebcalu_pkg::*;

    typedef struct packed {
        logic [ACC_W-1:0]  acc;
        logic [FLAG_W-1:0] flags;
    } alu_word_t;

    class alu_scoreboard;
        alu_word_t pending_q[$];
        int        errors;

        function logic [7:0] with_znhc(logic [7:0] f, logic [7:0] r8, logic n, logic h,
                                       logic c);
            f[FLAG_Z] = (r8 == 8'h00);
            f[FLAG_N] = n;
            f[FLAG_H] = h;
            f[FLAG_C] = c;
            return f;
        endfunction

        function alu_word_t predict_alu(logic [4:0] op, logic [15:0] acc, logic [15:0] opb,
                                        logic [7:0] flags);
            logic [7:0]  a;
            logic [7:0]  b;
            logic [7:0]  msk;
            logic [7:0]  r8;
            logic [7:0]  k;
            logic [15:0] r;
            logic [7:0]  f;
            logic [8:0]  t9;
            logic [16:0] t17;
            logic [12:0] h13;
            logic [4:0]  h5;
            logic        cin;
            logic        n;
            logic        c;
            alu_word_t   res;

            a   = acc[7:0];
            b   = opb[7:0];
            f   = flags;
            cin = flags[FLAG_C];
            msk = 8'h01 << opb[2:0];
            r   = acc;
            case (op)
                OP_LD8:  r = {8'h00, b};
                OP_LD16: r = opb;
                OP_ADD8:
                begin
                    t9 = {1'b0, a} + {1'b0, b};
                    h5 = {1'b0, a[3:0]} + {1'b0, b[3:0]};
                    r  = {8'h00, t9[7:0]};
                    f  = with_znhc(f, t9[7:0], 1'b0, h5[4], t9[8]);
                end
                OP_ADC8:
                begin
                    t9 = {1'b0, a} + {1'b0, b} + {8'd0, cin};
                    h5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
                    r  = {8'h00, t9[7:0]};
                    f  = with_znhc(f, t9[7:0], 1'b0, h5[4], t9[8]);
                end
                OP_SUB8, OP_CP:
                begin
                    r8 = a - b;
                    if (op == OP_SUB8)
                        r = {8'h00, r8};
                    f = with_znhc(f, r8, 1'b1, a[3:0] < b[3:0], a < b);
                end
                OP_SBC8:
                begin
                    r8 = a - b - {7'd0, cin};
                    r  = {8'h00, r8};
                    f  = with_znhc(f, r8, 1'b1,
                                   {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'd0, cin}),
                                   {1'b0, a} < ({1'b0, b} + {8'd0, cin}));
                end
                OP_INC8:
                begin
                    r8 = a + 8'h01;
                    r  = {8'h00, r8};
                    f  = with_znhc(f, r8, 1'b0, a[3:0] == 4'hF, cin);
                end
                OP_DEC8:
                begin
                    r8 = a - 8'h01;
                    r  = {8'h00, r8};
                    f  = with_znhc(f, r8, 1'b1, a[3:0] == 4'h0, cin);
                end
                OP_ADD16:
                begin
                    t17 = {1'b0, acc} + {1'b0, opb};
                    h13 = {1'b0, acc[11:0]} + {1'b0, opb[11:0]};
                    r   = t17[15:0];
                    f[FLAG_N] = 1'b0;
                    f[FLAG_H] = h13[12];
                    f[FLAG_C] = t17[16];
                end
                OP_SUB16:
                begin
                    r = acc - opb;
                    f[FLAG_Z] = (r == 16'h0000);
                    f[FLAG_N] = 1'b1;
                    f[FLAG_H] = acc[7:0] < opb[7:0];
                    f[FLAG_C] = acc < opb;
                end
                OP_INC16: r = acc + 16'h0001;
                OP_DEC16: r = acc - 16'h0001;
                OP_AND:
                begin
                    r = {8'h00, a & b};
                    f = with_znhc(f, a & b, 1'b0, 1'b1, 1'b0);
                end
                OP_XOR:
                begin
                    r = {8'h00, a ^ b};
                    f = with_znhc(f, a ^ b, 1'b0, 1'b0, 1'b0);
                end
                OP_OR:
                begin
                    r = {8'h00, a | b};
                    f = with_znhc(f, a | b, 1'b0, 1'b0, 1'b0);
                end
                OP_BIT:
                begin
                    f[FLAG_Z] = ((a & msk) == 8'h00);
                    f[FLAG_N] = 1'b0;
                    f[FLAG_H] = 1'b1;
                end
                OP_SET: r = {8'h00, a | msk};
                OP_RES: r = {8'h00, a & ~msk};
                OP_CPL:
                begin
                    r = {8'h00, ~a};
                    f[FLAG_N] = 1'b1;
                    f[FLAG_H] = 1'b1;
                end
                OP_RL, OP_RR, OP_RLC, OP_RRC, OP_SLA, OP_SRA, OP_SRL:
                begin
                    case (op)
                        OP_RL:   r8 = {a[6:0], cin};
                        OP_RR:   r8 = {cin, a[7:1]};
                        OP_RLC:  r8 = {a[6:0], a[7]};
                        OP_RRC:  r8 = {a[0], a[7:1]};
                        OP_SLA:  r8 = {a[6:0], 1'b0};
                        OP_SRA:  r8 = {a[7], a[7:1]};
                        default: r8 = {1'b0, a[7:1]};
                    endcase
                    c = (op == OP_RL || op == OP_RLC || op == OP_SLA) ? a[7] : a[0];
                    r = {8'h00, r8};
                    f = with_znhc(f, r8, 1'b0, 1'b0, c);
                end
                OP_DAA:
                begin
                    n = flags[FLAG_N];
                    c = cin;
                    k = 8'h00;
                    if (flags[FLAG_H] || (!n && a[3:0] > DAA_NIB))
                        k = DAA_LO;
                    if (c || (!n && a > DAA_LIMIT))
                    begin
                        k = k | DAA_HI;
                        c = 1'b1;
                    end
                    r8 = n ? (a - k) : (a + k);
                    r  = {8'h00, r8};
                    f  = with_znhc(f, r8, n, 1'b0, c);
                end
                OP_CCF:
                begin
                    f[FLAG_N] = 1'b0;
                    f[FLAG_H] = 1'b0;
                    f[FLAG_C] = ~cin;
                end
                OP_SCF:
                begin
                    f[FLAG_N] = 1'b0;
                    f[FLAG_H] = 1'b0;
                    f[FLAG_C] = 1'b1;
                end
                OP_SWAP:
                begin
                    r = {8'h00, a[3:0], a[7:4]};
                    f = with_znhc(f, {a[3:0], a[7:4]}, 1'b0, 1'b0, 1'b0);
                end
                default: ;
            endcase
            res.acc   = r;
            res.flags = f;
            return res;
        endfunction

        function void note_request(logic [4:0] op, logic [15:0] acc, logic [15:0] opb,
                                   logic [7:0] flags);
            pending_q.push_back(predict_alu(op, acc, opb, flags));
        endfunction

        function void check_response(logic [15:0] acc, logic [7:0] flags);
            alu_word_t want;

            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected response word acc_out %h flags_out %h",
                         $time, acc, flags);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (acc !== want.acc)
            begin
                $display("%0t: acc_out expected %h actual %h", $time, want.acc, acc);
                errors++;
            end
            if (flags !== want.flags)
            begin
                $display("%0t: flags_out expected %h actual %h", $time, want.flags, flags);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   rsp_count = 0;

    alu_scoreboard scb = new;

    ebcalu_req_if req_ch();
    ebcalu_rsp_if rsp_ch();

    eight_bit_cpu_alu_with_flags_top u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            scb.check_response(rsp_ch.acc_out, rsp_ch.flags_out);
            rsp_count++;
        end
    end

    task automatic send_word(input logic [4:0] op, input logic [15:0] acc,
                             input logic [15:0] opb, input logic [7:0] flags);
        @(negedge clk);
        req_ch.valid     = 1'b1;
        req_ch.req_type  = op;
        req_ch.acc_in    = acc;
        req_ch.operand_b = opb;
        req_ch.flags_in  = flags;
        do
            @(posedge clk);
        while (!req_ch.ready);
        scb.note_request(op, acc, opb, flags);
    endtask

    task automatic idle_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            req_ch.valid     = 1'b0;
            req_ch.req_type  = 5'($urandom);
            req_ch.acc_in    = 16'($urandom);
            req_ch.operand_b = 16'($urandom);
            req_ch.flags_in  = 8'($urandom);
        end
    endtask

    // low bytes near the carry, nibble and decimal boundaries, random high byte
    function automatic logic [15:0] pick_word();
        logic [7:0] hi;

        hi = 8'($urandom);
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return {hi, 8'h99};
            3: return {hi, 8'h9A};
            4: return {hi, 8'h0F};
            5: return {hi, 8'h80};
            6: return {hi, 8'h01};
            7: return {4'hF, 12'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver: changing stall patterns, one long hold-off to fill the pipeline
    initial
    begin
        int  phase_len;
        int  mode;
        int  tick;
        bit  held_long;

        held_long       = 1'b0;
        tick            = 0;
        rsp_ch.ready    = 1'b0;
        wait (rst_n);
        forever
        begin
            phase_len = $urandom_range(20, 80);
            mode      = $urandom_range(0, 3);
            repeat (phase_len)
            begin
                @(negedge clk);
                tick++;
                if (!held_long && rsp_count >= 400)
                begin
                    held_long    = 1'b1;
                    rsp_ch.ready = 1'b0;
                    repeat (100) @(negedge clk);
                end
                case (mode)
                    0: rsp_ch.ready = 1'b1;
                    1: rsp_ch.ready = 1'($urandom_range(0, 1));
                    2: rsp_ch.ready = tick[0];
                    default: rsp_ch.ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        #(12 * 200000);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int sent;
        int burst;

        req_ch.valid     = 1'b0;
        req_ch.req_type  = '0;
        req_ch.acc_in    = '0;
        req_ch.operand_b = '0;
        req_ch.flags_in  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every code once, including the unused one, at operand extremes
        for (int i = 0; i < 32; i++)
            send_word(5'(i), i[0] ? 16'hFFFF : 16'h0000, i[1] ? 16'hFFFF : 16'h0001,
                      i[2] ? 8'hFF : 8'h0F);
        send_word(OP_BIT, 16'h0002, 16'hFFF9, 8'h00);   // index above seven wraps
        send_word(OP_DAA, 16'h009A, 16'h0000, 8'h00);
        send_word(OP_DAA, 16'h0000, 16'h0000, 8'h70);   // subtract with both borrows
        send_word(OP_ADD16, 16'h0FFF, 16'h0001, 8'h80);  // carry out of bit 11, Z kept
        send_word(OP_ADD8, 16'hAB01, 16'hCD02, 8'h00);   // high bytes ignored

        sent = 0;
        while (sent < 1350)
        begin
            burst = $urandom_range(1, 30);
            repeat (burst)
            begin
                send_word(($urandom_range(0, 99) < 2) ? 5'd31 : 5'($urandom_range(0, 30)),
                          pick_word(), pick_word(), 8'($urandom));
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 6));
        end
        idle_sender(1);

        while (scb.outstanding() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (scb.errors == 0 && scb.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
design/ebcalu_pkg.sv
design/ebcalu_if.sv
design/eight_bit_cpu_alu_with_flags_top.sv
sim/eight_bit_cpu_alu_with_flags_top_test.sv
